FILE: design/brx_pkg.sv
package brx_pkg;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	// register word index, taken from paddr[3:2]
	localparam logic [1:0] REG_HDR_TMO  = 2'd0;
	localparam logic [1:0] REG_BODY_TMO = 2'd1;
	localparam logic [1:0] REG_CHECK_EN = 2'd2;

	localparam logic [15:0] HDR_TMO_RST  = 16'd400;
	localparam logic [15:0] BODY_TMO_RST = 16'd600;

	localparam logic [7:0] BYTE_X   = 8'h58;
	localparam logic [7:0] BYTE_B   = 8'h42;
	localparam logic [7:0] SUM_INIT = 8'h9A;
	localparam int         HDR_LEN  = 4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_LEN_ERR = 2'd1;
	localparam logic [1:0] ST_SUM_ERR = 2'd2;
	localparam logic [1:0] ST_TIMEOUT = 2'd3;

	typedef struct packed {
		logic [15:0] hdr_tmo;
		logic [15:0] body_tmo;
		logic        check_en;
	} brx_cfg_t;

	typedef struct packed {
		logic       clr_timer;
		logic       inc_timer;
		logic       init_sum;
		logic       add_sum;
		logic       load_len;
		logic       load_head;
		logic       clr_cnt;
		logic       inc_cnt;
		logic       wr_mem;
		logic       rd_mem;
		logic       load_err;
		logic [1:0] err_code;
		logic       load_frame;
	} brx_cmd_t;

	typedef struct packed {
		logic is_x;
		logic is_b;
		logic len_bad;
		logic head_done;
		logic pay_empty;
		logic pay_done;
		logic sum_ok;
		logic tmo_hdr;
		logic tmo_body;
		logic emit_last;
		logic out_blocked;
		logic slot_free;
	} brx_sts_t;

endpackage

FILE: design/brx_regs.sv
module brx_regs
	import brx_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output brx_cfg_t           cfg
);

	brx_cfg_t   cfg_q;
	logic       wr_en;
	logic [1:0] widx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign widx   = paddr[3:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hdr_tmo  <= HDR_TMO_RST;
			cfg_q.body_tmo <= BODY_TMO_RST;
			cfg_q.check_en <= 1'b1;
		end else if (wr_en) begin
			case (widx)
				REG_HDR_TMO:  cfg_q.hdr_tmo  <= pwdata[15:0];
				REG_BODY_TMO: cfg_q.body_tmo <= pwdata[15:0];
				REG_CHECK_EN: cfg_q.check_en <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (widx)
			REG_HDR_TMO:  prdata = {16'd0, cfg_q.hdr_tmo};
			REG_BODY_TMO: prdata = {16'd0, cfg_q.body_tmo};
			REG_CHECK_EN: prdata = {31'd0, cfg_q.check_en};
			default:      prdata = '0;
		endcase
	end

endmodule

FILE: design/brx_dp.sv
module brx_dp
	import brx_pkg::*;
#(
	parameter int MAX_FRAME_LEN = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  rx_byte,
	input  brx_cmd_t    cmd,
	input  brx_cfg_t    cfg,
	input  logic        out_stall,
	output brx_sts_t    sts,
	output logic        out_valid,
	output logic [1:0]  status,
	output logic [7:0]  seq_number,
	output logic [7:0]  action_code,
	output logic [7:0]  key_first,
	output logic [7:0]  key_second,
	output logic [5:0]  payload_length,
	output logic [7:0]  payload_byte,
	output logic [5:0]  payload_index,
	output logic        last
);

	localparam int STORE_DEPTH = (MAX_FRAME_LEN > HDR_LEN) ? MAX_FRAME_LEN - HDR_LEN : 1;
	localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam logic [7:0] MAX_LEN_B = 8'(MAX_FRAME_LEN);
	localparam logic [7:0] MIN_LEN_B = 8'(HDR_LEN);

	logic [7:0]  hdr_q [HDR_LEN];
	logic [7:0]  mem   [STORE_DEPTH];
	logic [7:0]  rd_data_q;
	logic [5:0]  plen_q;
	logic [5:0]  cnt_q;
	logic [7:0]  sum_q;
	logic [15:0] timer_q;
	logic [15:0] timer_inc;
	logic        last_pos;

	logic        out_valid_q;
	logic [1:0]  status_q;
	logic [7:0]  seq_q, act_q, key1_q, key2_q, pbyte_q;
	logic [5:0]  plen_out_q, pidx_q;
	logic        last_q;

	assign timer_inc = (timer_q == 16'hFFFF) ? timer_q : timer_q + 16'd1;
	assign last_pos  = (cnt_q == plen_q - 6'd1);

	always_comb begin
		sts.is_x        = (rx_byte == BYTE_X);
		sts.is_b        = (rx_byte == BYTE_B);
		sts.len_bad     = (rx_byte < MIN_LEN_B) || (rx_byte > MAX_LEN_B);
		sts.head_done   = (cnt_q == 6'(HDR_LEN - 1));
		sts.pay_empty   = (plen_q == 6'd0);
		sts.pay_done    = last_pos;
		sts.sum_ok      = !cfg.check_en || (rx_byte == sum_q);
		sts.tmo_hdr     = (timer_inc > cfg.hdr_tmo);
		sts.tmo_body    = (timer_inc > cfg.body_tmo);
		sts.emit_last   = (plen_q == 6'd0) || last_pos;
		sts.out_blocked = out_valid_q && out_stall;
		sts.slot_free   = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q <= '0;
			cnt_q   <= '0;
			sum_q   <= '0;
			plen_q  <= '0;
		end else begin
			if (cmd.clr_timer)
				timer_q <= '0;
			else if (cmd.inc_timer)
				timer_q <= timer_inc;

			if (cmd.clr_cnt)
				cnt_q <= '0;
			else if (cmd.inc_cnt)
				cnt_q <= cnt_q + 6'd1;

			if (cmd.init_sum)
				sum_q <= SUM_INIT;
			else if (cmd.add_sum)
				sum_q <= sum_q + rx_byte;

			// length already range-checked, so L-4 fits six bits
			if (cmd.load_len)
				plen_q <= 6'(rx_byte - MIN_LEN_B);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_head)
			hdr_q[cnt_q[1:0]] <= rx_byte;
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_mem)
			mem[cnt_q[AW-1:0]] <= rx_byte;
		if (cmd.rd_mem)
			rd_data_q <= mem[cnt_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_err || cmd.load_frame)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_err) begin
			status_q   <= cmd.err_code;
			seq_q      <= '0;
			act_q      <= '0;
			key1_q     <= '0;
			key2_q     <= '0;
			plen_out_q <= '0;
			pbyte_q    <= '0;
			pidx_q     <= '0;
			last_q     <= 1'b1;
		end else if (cmd.load_frame) begin
			status_q   <= ST_OK;
			seq_q      <= hdr_q[0];
			act_q      <= hdr_q[1];
			key1_q     <= hdr_q[2];
			key2_q     <= hdr_q[3];
			plen_out_q <= plen_q;
			pbyte_q    <= (plen_q == 6'd0) ? 8'd0 : rd_data_q;
			pidx_q     <= cnt_q;
			last_q     <= sts.emit_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign seq_number     = seq_q;
	assign action_code    = act_q;
	assign key_first      = key1_q;
	assign key_second     = key2_q;
	assign payload_length = plen_out_q;
	assign payload_byte   = pbyte_q;
	assign payload_index  = pidx_q;
	assign last           = last_q;

	// never overwrite a result that is still held by the consumer
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_err || cmd.load_frame) |-> !(out_valid_q && out_stall))
		else $error("result register overwritten while stalled");

	a_timer_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(timer_q == 16'hFFFF && cmd.inc_timer && !cmd.clr_timer) |=> timer_q == 16'hFFFF)
		else $error("timeout counter wrapped");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_err |=> (last_q && status_q != ST_OK && pidx_q == 6'd0))
		else $error("error result malformed");

endmodule

FILE: design/brx_ctrl.sv
module brx_ctrl
	import brx_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     command,
	input  brx_sts_t sts,
	output logic     in_stall,
	output brx_cmd_t cmd
);

	typedef enum logic [7:0] {
		S_HUNT_X  = 8'b0000_0001,
		S_HUNT_B  = 8'b0000_0010,
		S_LEN     = 8'b0000_0100,
		S_HEAD    = 8'b0000_1000,
		S_PAYLOAD = 8'b0001_0000,
		S_CHECK   = 8'b0010_0000,
		S_EMIT_RD = 8'b0100_0000,
		S_EMIT_LD = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   emitting;
	logic   accept;
	logic   tick;
	logic   tmo;

	assign emitting = (state_q == S_EMIT_RD) || (state_q == S_EMIT_LD);
	assign in_stall = emitting || sts.out_blocked;
	assign accept   = in_valid && !in_stall;
	assign tick     = accept && command;
	assign tmo      = ((state_q == S_PAYLOAD) || (state_q == S_CHECK)) ? sts.tmo_body
	                                                                  : sts.tmo_hdr;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		if (tick) begin
			if (state_q != S_HUNT_X) begin
				cmd.inc_timer = 1'b1;
				if (tmo) begin
					cmd.load_err = 1'b1;
					cmd.err_code = ST_TIMEOUT;
					state_d      = S_HUNT_X;
				end
			end
		end else begin
			case (state_q)
				S_HUNT_X: begin
					if (accept && sts.is_x) begin
						cmd.clr_timer = 1'b1;
						state_d       = S_HUNT_B;
					end
				end
				S_HUNT_B: begin
					if (accept) begin
						cmd.init_sum = sts.is_b;
						state_d      = sts.is_b ? S_LEN : S_HUNT_X;
					end
				end
				S_LEN: begin
					if (accept) begin
						if (sts.len_bad) begin
							cmd.load_err = 1'b1;
							cmd.err_code = ST_LEN_ERR;
							state_d      = S_HUNT_X;
						end else begin
							cmd.load_len = 1'b1;
							cmd.add_sum  = 1'b1;
							cmd.clr_cnt  = 1'b1;
							state_d      = S_HEAD;
						end
					end
				end
				S_HEAD: begin
					if (accept) begin
						cmd.load_head = 1'b1;
						cmd.add_sum   = 1'b1;
						if (sts.head_done) begin
							cmd.clr_cnt   = 1'b1;
							cmd.clr_timer = 1'b1;
							state_d       = sts.pay_empty ? S_CHECK : S_PAYLOAD;
						end else begin
							cmd.inc_cnt = 1'b1;
						end
					end
				end
				S_PAYLOAD: begin
					if (accept) begin
						cmd.wr_mem  = 1'b1;
						cmd.add_sum = 1'b1;
						if (sts.pay_done) begin
							cmd.clr_cnt = 1'b1;
							state_d     = S_CHECK;
						end else begin
							cmd.inc_cnt = 1'b1;
						end
					end
				end
				S_CHECK: begin
					if (accept) begin
						if (!sts.sum_ok) begin
							cmd.load_err = 1'b1;
							cmd.err_code = ST_SUM_ERR;
							state_d      = S_HUNT_X;
						end else begin
							cmd.clr_cnt = 1'b1;
							state_d     = S_EMIT_RD;
						end
					end
				end
				S_EMIT_RD: begin
					cmd.rd_mem = 1'b1;
					state_d    = S_EMIT_LD;
				end
				S_EMIT_LD: begin
					// hold the read byte until the result register frees up
					if (sts.slot_free) begin
						cmd.load_frame = 1'b1;
						if (sts.emit_last) begin
							state_d = S_HUNT_X;
						end else begin
							cmd.inc_cnt = 1'b1;
							state_d     = S_EMIT_RD;
						end
					end
				end
				default: state_d = S_HUNT_X;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_HUNT_X;
		else
			state_q <= state_d;
	end

endmodule

FILE: design/bridge_frame_receiver.sv
// Length-prefixed frame receiver. Each input transaction carries either a received
// byte or a one-millisecond tick; a transaction is taken in a cycle where in_valid
// is high and in_stall is low. After a frame's checksum byte matches (or checking is
// disabled), the block stops taking input and plays the stored payload out of its
// payload memory, each result taking a memory read and then a result register
// load and waiting out any consumer stall; an empty payload gives one result. Length,
// checksum and timeout errors give a single result with last set. Input is also held
// off while a finished result waits in the output register under stall. The payload
// memory needs no clearing pass after reset.
module bridge_frame_receiver
	import brx_pkg::*;
#(
	parameter int MAX_FRAME_LEN = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               command,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic [7:0]         seq_number,
	output logic [7:0]         action_code,
	output logic [7:0]         key_first,
	output logic [7:0]         key_second,
	output logic [5:0]         payload_length,
	output logic [7:0]         payload_byte,
	output logic [5:0]         payload_index,
	output logic               last
);

	brx_cfg_t cfg;
	brx_cmd_t cmd;
	brx_sts_t sts;

	brx_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	brx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.command  (command),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	brx_dp #(
		.MAX_FRAME_LEN (MAX_FRAME_LEN)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.rx_byte        (rx_byte),
		.cmd            (cmd),
		.cfg            (cfg),
		.out_stall      (out_stall),
		.sts            (sts),
		.out_valid      (out_valid),
		.status         (status),
		.seq_number     (seq_number),
		.action_code    (action_code),
		.key_first      (key_first),
		.key_second     (key_second),
		.payload_length (payload_length),
		.payload_byte   (payload_byte),
		.payload_index  (payload_index),
		.last           (last)
	);

endmodule
